// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probing hash table
// Field widths, operation and result codes, slot states and the layout of
// one table entry as it is held in the entry memory.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Field widths of the command and result channels.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RES_W  = 2;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned ST_W   = 2;

  // Operation codes. The spare code is answered as key not found.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  // Result codes.
  typedef enum logic [RES_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_e;

  // Slot states. A deleted slot is a tombstone.
  typedef enum logic [ST_W-1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2
  } slot_st_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SCAN
  } state_e;

  // One word of the entry memory.
  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// File: rtl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressing key/value table
// Insert, search and delete with linear probing and tombstones, the table
// held in one single-port-write, registered-read entry memory.
// ----------------------------------------------------------------------------
// Usage
//   Commands: a transfer takes place at a rising edge where start is high and
//   busy is low, carrying operation_i, key_i and value_i.
//   Results: each command gives exactly one result, shown for one cycle with
//   result_valid_o high. The receiver cannot stall; the result is taken in
//   that cycle. A new command may be sent in the same cycle.
//   Timing: after the command transfer, the hash state forms the home slot and
//   issues the first memory read, then the probe inspects one slot per
//   cycle, since the entry memory returns one word per cycle. Busy stays high
//   through the hash state and the slot inspections, and the result appears in
//   the cycle after the last inspection.
//   When TABLE_SIZE is not a power of two the home slot comes from a
//   reciprocal multiplication started at the transfer; the timing is the same.
//   Reset: the controller sweeps the memory once, one entry per cycle,
//   marking every slot empty; busy stays high until the last slot is cleared.
//   A probe that inspects every slot without a decision answers table full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [lpht_pkg::OP_W-1:0]           operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]          key_i,
  input  logic signed [lpht_pkg::VAL_W-1:0]   value_i,
  output logic                                result_valid_o,
  output logic [lpht_pkg::RES_W-1:0]          status_o,
  output logic signed [lpht_pkg::VAL_W-1:0]   found_value_o,
  output logic [lpht_pkg::SLOT_W-1:0]         slot_o
);

  import lpht_pkg::*;

  localparam int unsigned AW       = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST   = AW'(TABLE_SIZE - 1);
  localparam bit          IS_POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  // Step to the following slot, wrapping from the last slot to slot zero.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == LAST) ? '0 : s + AW'(1);
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0]    clr_q, clr_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [AW-1:0]    probe_q, probe_d;
  logic [AW-1:0]    chk_q, chk_d;
  logic [AW-1:0]    n_q, n_d;

  logic             res_valid_q, res_valid_d;
  logic [RES_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;

  logic             accept;
  logic             hash_done;
  logic [AW-1:0]    home;

  // Entry memory and its ports.
  entry_t           mem_q [TABLE_SIZE];
  entry_t           rd_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  entry_t           mem_wd;

  logic             key_hit;
  logic             last_slot;
  logic [31:0]      slot_wide;

  assign accept = start && !busy;

  // Home slot: a mask for a power-of-two table, a reciprocal multiplication else.
  if (IS_POW2) begin : g_mask
    assign hash_done = 1'b1;
    assign home      = key_q[AW-1:0];
  end else begin : g_rem
    // Reciprocal of the table size, rounded up, so that the quotient taken
    // from the top of the product is exact for every key.
    localparam int unsigned RSH   = KEY_W + AW;
    localparam logic [31:0] RECIP =
      32'(((64'd1 << RSH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    logic [KEY_W+31:0] prod_q;
    logic [AW-1:0]     quot;
    logic [2*AW-1:0]   quot_mul;

    // The product is formed at the command transfer from the key on the port.
    always_ff @(posedge clk_i) begin
      if (accept) begin
        prod_q <= (KEY_W+32)'(key_i) * (KEY_W+32)'(RECIP);
      end
    end

    // The remainder is below the table size, so the low bits of the quotient
    // and of the key are all that is needed.
    assign quot      = prod_q[RSH +: AW];
    assign quot_mul  = (2*AW)'(quot) * (2*AW)'(TABLE_SIZE);
    assign hash_done = 1'b1;
    assign home      = key_q[AW-1:0] - quot_mul[AW-1:0];
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign key_hit   = (rd_q.key == key_q);
  assign last_slot = (n_q == LAST);
  assign slot_wide = 32'(chk_q);

  // Next state, memory control and result formation.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    probe_d      = probe_q;
    chk_d        = chk_q;
    n_d          = n_q;
    rd_addr      = probe_q;
    mem_we       = 1'b0;
    mem_wa       = chk_q;
    mem_wd       = rd_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_q;
        mem_wd    = '{st: ST_EMPTY, key: '0, value: '0};
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d    = operation_i;
          key_d   = key_i;
          val_d   = value_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          rd_addr = home;
          chk_d   = home;
          probe_d = next_slot(home);
          n_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // The word of slot chk_q is in rd_q; the read of probe_q goes ahead.
        rd_addr = probe_q;
        chk_d   = probe_q;
        probe_d = next_slot(probe_q);
        n_d     = n_q + AW'(1);
        case (op_q) inside
          OP_INSERT: begin
            if (rd_q.st != ST_USED) begin
              mem_we       = 1'b1;
              mem_wd       = '{st: ST_USED, key: key_q, value: val_q};
              res_valid_d  = 1'b1;
              res_status_d = RES_OK;
              res_value_d  = '0;
              res_slot_d   = slot_wide[SLOT_W-1:0];
            end else if (last_slot) begin
              res_valid_d  = 1'b1;
              res_status_d = RES_FULL;
              res_value_d  = '0;
              res_slot_d   = '0;
            end
          end
          OP_SEARCH, OP_DELETE: begin
            if (rd_q.st == ST_EMPTY) begin
              res_valid_d  = 1'b1;
              res_status_d = RES_NOT_FOUND;
              res_value_d  = '0;
              res_slot_d   = '0;
            end else if (rd_q.st == ST_USED && key_hit) begin
              if (op_q == OP_DELETE) begin
                mem_we    = 1'b1;
                mem_wd.st = ST_DELETED;
              end
              res_valid_d  = 1'b1;
              res_status_d = RES_OK;
              res_value_d  = rd_q.value;
              res_slot_d   = slot_wide[SLOT_W-1:0];
            end else if (last_slot) begin
              res_valid_d  = 1'b1;
              res_status_d = RES_FULL;
              res_value_d  = '0;
              res_slot_d   = '0;
            end
          end
          default: begin
            // The spare operation code changes nothing.
            res_valid_d  = 1'b1;
            res_status_d = RES_NOT_FOUND;
            res_value_d  = '0;
            res_slot_d   = '0;
          end
        endcase
        if (res_valid_d) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    probe_q      <= probe_d;
    chk_q        <= chk_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign found_value_o  = $signed(res_value_q);
  assign slot_o         = res_slot_q;

  // A result is only ever produced by the slot inspection.
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_SCAN))
    else $error("result strobe without a preceding slot inspection");

  // The block is ready again when its result is shown.
  a_result_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while a result is shown");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("command transfer not followed by busy");

  // The memory is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("entry memory written while idle");

endmodule

// File: tb/sv/linear_probe_hash_table_core_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core_tb: self-checking bench for the hash table
// Drives insert, search and delete commands into the core and keeps a shadow
// copy of the table. Every result is checked against the shadow copy's
// prediction in order. The run covers directed corner cases, random traffic
// under three sender idling patterns and a completely filled table.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int unsigned TBL_SIZE = 1024;
  // The fourth operation code has no meaning and is answered as key not found.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    res_e              status;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } table_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          operation_i = '0;
  logic [KEY_W-1:0]         key_i = '0;
  logic signed [VAL_W-1:0]  value_i = '0;
  logic                     result_valid_o;
  logic [RES_W-1:0]         status_o;
  logic signed [VAL_W-1:0]  found_value_o;
  logic [SLOT_W-1:0]        slot_o;

  // Shadow copy of the table contents.
  slot_st_e          shadow_st  [TBL_SIZE];
  logic [KEY_W-1:0]  shadow_key [TBL_SIZE];
  logic [VAL_W-1:0]  shadow_val [TBL_SIZE];

  table_result_t pending_results[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   op_count [4];
  int unsigned   status_count [4];

  linear_probe_hash_table_core #(
    .TABLE_SIZE(TBL_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .slot_o        (slot_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one command to the shadow table and returns the answer it should give.
  function automatic table_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val);
    table_result_t r;
    int unsigned   s;
    int unsigned   n;
    bit            done;
    r.status = RES_NOT_FOUND;
    r.value  = '0;
    r.slot   = '0;
    s        = key % TBL_SIZE;
    done     = 1'b0;
    case (op) inside
      OP_INSERT: begin
        // Take the first slot that is not occupied; a full lap means no room.
        r.status = RES_FULL;
        for (n = 0; n < TBL_SIZE && !done; n++) begin
          if (shadow_st[s] != ST_USED) begin
            shadow_st[s]  = ST_USED;
            shadow_key[s] = key;
            shadow_val[s] = val;
            r.status      = RES_OK;
            r.slot        = s[SLOT_W-1:0];
            done          = 1'b1;
          end else begin
            s = (s + 1) % TBL_SIZE;
          end
        end
      end
      OP_SEARCH, OP_DELETE: begin
        // Walk past tombstones and other keys until an empty slot or a match.
        r.status = RES_FULL;
        for (n = 0; n < TBL_SIZE && !done; n++) begin
          if (shadow_st[s] == ST_EMPTY) begin
            r.status = RES_NOT_FOUND;
            done     = 1'b1;
          end else if (shadow_st[s] == ST_USED && shadow_key[s] == key) begin
            r.status = RES_OK;
            r.value  = shadow_val[s];
            r.slot   = s[SLOT_W-1:0];
            if (op == OP_DELETE) begin
              shadow_st[s] = ST_DELETED;
            end
            done = 1'b1;
          end else begin
            s = (s + 1) % TBL_SIZE;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [31:0] r;
    r = $urandom();
    return r[KEY_W-1:0];
  endfunction

  // Key of a random non-empty slot, tombstones included, or a fresh key.
  function automatic logic [KEY_W-1:0] stored_key();
    int unsigned s;
    for (int i = 0; i < 8; i++) begin
      s = $urandom_range(TBL_SIZE - 1);
      if (shadow_st[s] != ST_EMPTY) begin
        return shadow_key[s];
      end
    end
    return rand_key();
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Checks each result against the oldest prediction, then records any
  // command transfer taking place at this edge.
  always @(posedge clk_i) begin : result_monitor
    table_result_t want;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result: status %0d value %0d slot %0d",
                                  status_o, found_value_o, slot_o));
        end else begin
          want = pending_results.pop_front();
          status_count[want.status]++;
          if (status_o !== want.status || found_value_o !== want.value ||
              slot_o !== want.slot) begin
            note_mismatch($sformatf({"expected status %0d value %0d slot %0d, ",
                                     "got status %0d value %0d slot %0d"},
                                    want.status, $signed(want.value), want.slot,
                                    status_o, found_value_o, slot_o));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pending_results.push_back(apply_table_op(operation_i, key_i, value_i));
        op_count[operation_i]++;
      end
    end
  end

  // Offers one command, idling first at random, and returns at its transfer.
  // Start is left high so that a back-to-back command is offered at once.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    value_i     <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Corner cases on the freshly cleared table: misses, the spare code, key
  // and data extremes, wrap-around, duplicate keys and tombstone handling.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    send_command(OP_SEARCH, '0, '0);
    send_command(OP_DELETE, '1, '1);
    send_command(OP_SPARE, '1, '1);
    send_command(OP_INSERT, '1, 32'h8000_0000);
    send_command(OP_INSERT, 31'd1023, 32'h7FFF_FFFF);
    send_command(OP_INSERT, '0, '0);
    send_command(OP_SEARCH, 31'd1023, '0);
    send_command(OP_SEARCH, '0, '1);
    send_command(OP_INSERT, 31'd5, '1);
    send_command(OP_INSERT, 31'd5, 32'h1234_5678);
    send_command(OP_SEARCH, 31'd5, '0);
    send_command(OP_DELETE, 31'd5, '0);
    send_command(OP_SEARCH, 31'd5, '0);
    send_command(OP_INSERT, 31'd1029, 32'h55AA_55AA);
    send_command(OP_DELETE, '1, '0);
    send_command(OP_SEARCH, 31'd1023, '0);
    send_command(OP_SEARCH, '1, '0);
    send_command(OP_DELETE, '1, '0);
    send_command(OP_SPARE, '0, '0);
  endtask

  // Mixed traffic: mostly keys already held, some fresh keys, a hot group of
  // home slots at the top of the table to build clusters that wrap round.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    int unsigned      pick;
    int unsigned      hot;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    send_idle_pct = idle_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3) op = OP_SPARE;
      else if (pick < 47) op = OP_INSERT;
      else if (pick < 77) op = OP_SEARCH;
      else op = OP_DELETE;
      pick = $urandom_range(9);
      if (pick < 3) begin
        key = rand_key();
      end else if (pick == 3) begin
        key = rand_key();
        hot = TBL_SIZE - 1 - $urandom_range(5);
        key[SLOT_W-1:0] = hot[SLOT_W-1:0];
      end else begin
        key = stored_key();
      end
      send_command(op, key, $urandom());
    end
  endtask

  // Fills every free slot, then probes the full table: full laps on insert,
  // search and delete, a lap over tombstones, and reuse of a tombstone.
  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    send_idle_pct = 0;
    wait_for_results();
    for (int unsigned s = 0; s < TBL_SIZE; s++) begin
      if (shadow_st[s] != ST_USED) begin
        key = rand_key();
        key[SLOT_W-1:0] = s[SLOT_W-1:0];
        send_command(OP_INSERT, key, $urandom());
      end
    end
    send_command(OP_INSERT, rand_key(), $urandom());
    send_command(OP_SEARCH, rand_key(), $urandom());
    send_command(OP_DELETE, rand_key(), $urandom());
    send_command(OP_SEARCH, shadow_key[TBL_SIZE-1], $urandom());
    send_idle_pct = 6;
    repeat (40) send_command(OP_DELETE, stored_key(), $urandom());
    send_command(OP_SEARCH, rand_key(), $urandom());
    send_command(OP_DELETE, rand_key(), $urandom());
    send_command(OP_INSERT, rand_key(), $urandom());
    send_command(OP_SPARE, rand_key(), $urandom());
  endtask

  initial begin
    for (int unsigned s = 0; s < TBL_SIZE; s++) begin
      shadow_st[s]  = ST_EMPTY;
      shadow_key[s] = '0;
      shadow_val[s] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(6, 330);
    test_random_traffic(70, 330);
    test_random_traffic(0, 330);
    test_full_table();

    wait_for_results();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d inserts, %0d searches, %0d deletes and %0d spare-code commands.",
             op_count[OP_INSERT], op_count[OP_SEARCH], op_count[OP_DELETE],
             op_count[OP_SPARE]);
    $display("Answers: %0d done or found, %0d not found, %0d table full; %0d mismatches.",
             status_count[RES_OK], status_count[RES_NOT_FOUND], status_count[RES_FULL],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guards against a hung handshake; far beyond the slowest correct run.
  initial begin
    #(64'd120_000_000);
    $display("Timeout waiting for the core.");
    $display("Mismatches found");
    $finish;
  end

endmodule
